/* hdl/histogram_median_threshold_macros.svh */
// assertion macros for the histogram median threshold block
// expects a clock named aclk and an active-low reset named aresetn in scope
`ifndef HISTOGRAM_MEDIAN_THRESHOLD_MACROS_SVH
`define HISTOGRAM_MEDIAN_THRESHOLD_MACROS_SVH

// same-cycle implication
`define HMT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/hmt_pkg.sv */
// shared constants, types and state encoding for the histogram median threshold
// no dependencies
`default_nettype none

package hmt_pkg;

    localparam int PIXEL_BITS   = 8;
    localparam int COUNT_BITS   = 24;
    localparam int NUM_BINS     = 1 << PIXEL_BITS;
    localparam int RUN_BITS     = COUNT_BITS + PIXEL_BITS;
    localparam int THR_BITS     = 8;
    localparam int IN_DATA_BITS = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int OUT_BITS     = ((THR_BITS + COUNT_BITS + 7) / 8) * 8;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [PIXEL_BITS-1:0] PIX_MAX = {PIXEL_BITS{1'b1}};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_FLUSH,
        ST_SCAN,
        ST_TAIL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept_en;
        logic clr_wr;
        logic cnt_inc;
        logic scan_rd;
        logic scan_init;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic cnt_at_max;
        logic last_fire;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

/* hdl/hmt_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module hmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/hmt_ctrl.sv */
// controller for the histogram median threshold: clear sweep, accumulate, scan, result
// depends on hmt_pkg
`default_nettype none

module hmt_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire hmt_pkg::status_t status,
    output hmt_pkg::cmd_t        cmd,
    output hmt_pkg::state_t      state
);

    hmt_pkg::state_t state_reg;
    hmt_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hmt_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hmt_pkg::ST_CLEAR: begin
                if (status.cnt_at_max) state_next = hmt_pkg::ST_RUN;
            end
            hmt_pkg::ST_RUN: begin
                if (status.last_fire) state_next = hmt_pkg::ST_FLUSH;
            end
            hmt_pkg::ST_FLUSH: begin
                state_next = hmt_pkg::ST_SCAN;
            end
            hmt_pkg::ST_SCAN: begin
                if (status.cnt_at_max) state_next = hmt_pkg::ST_TAIL;
            end
            hmt_pkg::ST_TAIL: begin
                state_next = hmt_pkg::ST_FINISH;
            end
            hmt_pkg::ST_FINISH: begin
                if (!status.out_busy) state_next = hmt_pkg::ST_RUN;
            end
            default: begin
                state_next = hmt_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            hmt_pkg::ST_CLEAR: begin
                cmd.clr_wr  = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            hmt_pkg::ST_RUN: begin
                cmd.accept_en = 1'b1;
            end
            hmt_pkg::ST_FLUSH: begin
                cmd.scan_init = 1'b1;
            end
            hmt_pkg::ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            hmt_pkg::ST_TAIL: begin
                cmd = '0;
            end
            hmt_pkg::ST_FINISH: begin
                cmd.out_load = !status.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign state = state_reg;

endmodule

`default_nettype wire

/* hdl/hmt_dp.sv */
// datapath for the histogram median threshold: bin ram, counters, scan sum, output register
// depends on hmt_pkg and hmt_ram
`default_nettype none

module hmt_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire hmt_pkg::cmd_t                     cmd,
    output hmt_pkg::status_t                       status,
    input  wire logic                              s_tvalid,
    input  wire logic [hmt_pkg::IN_DATA_BITS-1:0]  s_tdata,
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [hmt_pkg::OUT_BITS-1:0]      m_tdata
);

    logic                          acc_fire;
    logic [hmt_pkg::PIXEL_BITS-1:0] in_pix;

    logic                           acc_v_reg;
    logic [hmt_pkg::PIXEL_BITS-1:0] acc_pix_reg;
    logic                           scan_v_reg;
    logic [hmt_pkg::PIXEL_BITS-1:0] scan_addr_reg;
    logic                           fwd_v_reg;
    logic [hmt_pkg::PIXEL_BITS-1:0] fwd_addr_reg;
    logic [hmt_pkg::COUNT_BITS-1:0] fwd_data_reg;

    logic [hmt_pkg::PIXEL_BITS-1:0] cnt_reg;
    logic [hmt_pkg::COUNT_BITS-1:0] total_reg;
    logic [hmt_pkg::RUN_BITS-1:0]   run_reg;
    logic                           found_reg;
    logic [hmt_pkg::PIXEL_BITS-1:0] thr_reg;

    logic                           out_valid_reg;
    logic [hmt_pkg::THR_BITS-1:0]   out_thr_reg;
    logic [hmt_pkg::COUNT_BITS-1:0] out_cnt_reg;

    logic                           ram_we;
    logic [hmt_pkg::PIXEL_BITS-1:0] ram_waddr;
    logic [hmt_pkg::COUNT_BITS-1:0] ram_wdata;
    logic [hmt_pkg::PIXEL_BITS-1:0] ram_raddr;
    logic [hmt_pkg::COUNT_BITS-1:0] ram_rdata;

    logic [hmt_pkg::COUNT_BITS-1:0] bin_cur;
    logic [hmt_pkg::COUNT_BITS-1:0] bin_inc;
    logic [hmt_pkg::RUN_BITS-1:0]   run_sum;
    logic [hmt_pkg::RUN_BITS-1:0]   half;
    logic                           hit;

    assign acc_fire = s_tvalid && cmd.accept_en;
    assign in_pix   = s_tdata[hmt_pkg::PIXEL_BITS-1:0];

    assign ram_raddr = cmd.scan_rd ? cnt_reg : in_pix;

    assign bin_cur = (fwd_v_reg && (fwd_addr_reg == acc_pix_reg)) ? fwd_data_reg : ram_rdata;
    assign bin_inc = (bin_cur == hmt_pkg::CNT_MAX) ? hmt_pkg::CNT_MAX
                                                   : bin_cur + hmt_pkg::COUNT_BITS'(1);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = '0;
        if (acc_v_reg) begin
            ram_we    = 1'b1;
            ram_waddr = acc_pix_reg;
            ram_wdata = bin_inc;
        end else if (scan_v_reg) begin
            ram_we    = 1'b1;
            ram_waddr = scan_addr_reg;
        end else if (cmd.clr_wr) begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg;
        end
    end

    hmt_ram #(
        .WIDTH (hmt_pkg::COUNT_BITS),
        .DEPTH (hmt_pkg::NUM_BINS)
    ) u_bins (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign run_sum = run_reg + hmt_pkg::RUN_BITS'(ram_rdata);
    assign half    = hmt_pkg::RUN_BITS'(total_reg >> 1);
    assign hit     = scan_v_reg && !found_reg && (run_sum > half);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_v_reg     <= 1'b0;
            scan_v_reg    <= 1'b0;
            fwd_v_reg     <= 1'b0;
            cnt_reg       <= '0;
            total_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            acc_v_reg  <= acc_fire;
            scan_v_reg <= cmd.scan_rd;
            fwd_v_reg  <= acc_v_reg;
            if (cmd.cnt_inc) begin
                cnt_reg <= cnt_reg + hmt_pkg::PIXEL_BITS'(1);
            end
            if (cmd.out_load) begin
                total_reg <= '0;
            end else if (acc_fire && (total_reg != hmt_pkg::CNT_MAX)) begin
                total_reg <= total_reg + hmt_pkg::COUNT_BITS'(1);
            end
            if (cmd.scan_init) begin
                found_reg <= 1'b0;
            end else if (hit) begin
                found_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_pix_reg   <= in_pix;
        scan_addr_reg <= cnt_reg;
        fwd_addr_reg  <= acc_pix_reg;
        fwd_data_reg  <= bin_inc;
        if (cmd.scan_init) begin
            run_reg <= '0;
            thr_reg <= hmt_pkg::PIX_MAX;
        end else begin
            if (scan_v_reg) begin
                run_reg <= run_sum;
            end
            if (hit) begin
                thr_reg <= scan_addr_reg;
            end
        end
        if (cmd.out_load) begin
            out_thr_reg <= hmt_pkg::THR_BITS'(thr_reg);
            out_cnt_reg <= total_reg;
        end
    end

    assign status.cnt_at_max = (cnt_reg == hmt_pkg::PIX_MAX);
    assign status.last_fire  = acc_fire && s_tlast;
    assign status.out_busy   = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = hmt_pkg::OUT_BITS'({out_cnt_reg, out_thr_reg});

endmodule

`default_nettype wire

/* hdl/histogram_median_threshold.sv */
// top level of the histogram median threshold block
// depends on hmt_pkg, hmt_ctrl, hmt_dp, hmt_ram and histogram_median_threshold_macros.svh
//
// input channel s_*: one pixel per item, s_tdata[7:0] = pixel, s_tlast marks the
// last pixel of a frame. pixels are taken at one per cycle while a frame streams.
// each pixel adds one to its bin (256 bins in a ram) and to the frame total,
// both saturating. bins are read and written back over a two-stage loop with
// forwarding, so equal pixels on consecutive cycles count correctly.
// after the last pixel the block scans all 256 bins, one ram read per cycle,
// summing counts and clearing each bin; s_tready is low during the scan.
// after the last pixel is taken the block passes through a flush state, the
// scan, a tail state and a finish state, which loads the result onto m_*.
// no pixel of the next frame is taken until that result is loaded.
// result channel m_*: m_tdata[7:0] = threshold, m_tdata[31:8] = pixel count.
// the result waits in an output register; the next frame streams in meanwhile,
// and only the loading of its result waits, s_tready low, while m_tready stays low.
// after reset a clearing pass writes zero to all 256 bins, s_tready low.
`default_nettype none
`include "histogram_median_threshold_macros.svh"

module histogram_median_threshold (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [hmt_pkg::IN_DATA_BITS-1:0]  s_tdata,  // pixel
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [hmt_pkg::OUT_BITS-1:0]      m_tdata   // threshold, pixel_count
);

    hmt_pkg::cmd_t    cmd;
    hmt_pkg::status_t status;
    hmt_pkg::state_t  state;

    hmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cmd     (cmd),
        .state   (state)
    );

    hmt_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    assign s_tready = cmd.accept_en;

    `HMT_ASSERT_NOW(a_no_accept_in_scan, s_tready, !cmd.scan_rd && !cmd.clr_wr,
        "accept during scan or clear")
    `HMT_ASSERT_NOW(a_load_when_free, cmd.out_load, !status.out_busy,
        "result overwrites pending item")
    `HMT_ASSERT_NEXT(a_last_stops_input, s_tvalid && s_tready && s_tlast,
        !s_tready && (state == hmt_pkg::ST_FLUSH), "input not stopped after last pixel")
    `HMT_ASSERT_NOW(a_count_nonzero, m_tvalid, m_tdata[31:8] != 24'd0,
        "result with zero pixel count")

endmodule

`default_nettype wire

/* tb/histogram_median_threshold_test.sv */
// self-checking testbench for histogram_median_threshold: pixel frames in, median threshold out
// depends on hmt_pkg and the histogram_median_threshold rtl; predicts results not in the table
`default_nettype none

module histogram_median_threshold_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hmt_pkg::*;

    typedef struct packed {
        logic [THR_BITS-1:0]   thr;
        logic [COUNT_BITS-1:0] cnt;
    } frame_result_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pix;
        logic                  last;
        logic                  typed;
        logic [THR_BITS-1:0]   thr;
        logic [COUNT_BITS-1:0] cnt;
    } pixel_row_t;

    localparam int NUM_ROWS = 23;
    localparam int RANDOM_PIXELS = 500;
    localparam int SETTLE_CYCLES = 300;

    logic                    aclk;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_BITS-1:0] s_tdata = '0;  // pixel
    logic                    s_tlast = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_BITS-1:0]     m_tdata;       // threshold, pixel_count

    histogram_median_threshold uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // single-pixel frames at both extremes, ties at half, equal pixels back to back
    pixel_row_t dir_rows [NUM_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, 8'h00, 24'd1},
        '{8'hff, 1'b1, 1'b1, 8'hff, 24'd1},
        '{8'hff, 1'b0, 1'b0, 8'h00, 24'd0},
        '{8'h00, 1'b1, 1'b1, 8'hff, 24'd2},
        '{8'h00, 1'b0, 1'b0, 8'h00, 24'd0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 24'd0},
        '{8'hff, 1'b1, 1'b1, 8'h00, 24'd3},
        '{8'h55, 1'b0, 1'b0, 8'h00, 24'd0},
        '{8'haa, 1'b0, 1'b0, 8'h00, 24'd0},
        '{8'h0f, 1'b0, 1'b0, 8'h00, 24'd0},
        '{8'hf0, 1'b0, 1'b0, 8'h00, 24'd0},
        '{8'h01, 1'b0, 1'b0, 8'h00, 24'd0},
        '{8'h80, 1'b1, 1'b0, 8'h00, 24'd0},
        '{8'h07, 1'b0, 1'b0, 8'h00, 24'd0},
        '{8'h07, 1'b0, 1'b0, 8'h00, 24'd0},
        '{8'h07, 1'b0, 1'b0, 8'h00, 24'd0},
        '{8'h07, 1'b0, 1'b0, 8'h00, 24'd0},
        '{8'hc8, 1'b1, 1'b1, 8'h07, 24'd5},
        '{8'h07, 1'b0, 1'b0, 8'h00, 24'd0},
        '{8'h09, 1'b0, 1'b0, 8'h00, 24'd0},
        '{8'h07, 1'b0, 1'b0, 8'h00, 24'd0},
        '{8'h09, 1'b0, 1'b0, 8'h00, 24'd0},
        '{8'h09, 1'b1, 1'b0, 8'h00, 24'd0}
    };

    logic [COUNT_BITS-1:0] hist_bins [NUM_BINS] = '{default: '0};
    logic [COUNT_BITS-1:0] frame_total = '0;
    frame_result_t         pending_results [$];
    frame_result_t         want;
    frame_result_t         got;

    int unsigned errors = 0;
    int unsigned pixels_sent = 0;
    int unsigned frames_sent = 0;
    int unsigned results_seen = 0;
    int unsigned thr_lo = 255;
    int unsigned thr_hi = 0;
    int unsigned longest_frame = 0;
    int unsigned burst_left = 0;
    int unsigned ready_left = 0;
    int unsigned frame_len;
    int unsigned pause_frame;
    int unsigned spread;
    int unsigned center;
    int          pix_val;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("timeout with %0d results pending", pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what, input int unsigned seen,
                                   input int unsigned wanted);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, seen, wanted);
        errors++;
    endtask

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // adds one pixel to the histogram; at the frame end scans for the median bin
    function automatic bit count_pixel(input logic [PIXEL_BITS-1:0] pix, input logic last,
                                       output frame_result_t res);
        logic [RUN_BITS:0] running;
        bit                found;
        hist_bins[pix] = sat_inc(hist_bins[pix]);
        frame_total = sat_inc(frame_total);
        res = '0;
        if (!last) return 1'b0;
        running = '0;
        found = 1'b0;
        res.thr = THR_BITS'(PIX_MAX);
        for (int v = 0; v < NUM_BINS; v++) begin
            running += hist_bins[v];
            if (!found && running > (frame_total >> 1)) begin
                found = 1'b1;
                res.thr = THR_BITS'(v);
            end
        end
        res.cnt = frame_total;
        for (int v = 0; v < NUM_BINS; v++) hist_bins[v] = '0;
        frame_total = '0;
        return 1'b1;
    endfunction

    task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix, input logic last,
                              input logic typed, input frame_result_t typed_res);
        int unsigned   gap;
        frame_result_t res;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_BITS'(pix);
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
        if (count_pixel(pix, last, res)) begin
            frames_sent++;
            pending_results.push_back(typed ? typed_res : res);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
            send_pixel(dir_rows[i].pix, dir_rows[i].last, dir_rows[i].typed,
                       '{dir_rows[i].thr, dir_rows[i].cnt});
        drain_results();

        pause_frame = frames_sent + $urandom_range(5, 25);
        while (pixels_sent < RANDOM_PIXELS) begin
            frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64)
                                                    : $urandom_range(1, 12);
            if (frame_len > longest_frame) longest_frame = frame_len;
            center = $urandom_range(0, 255);
            spread = ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(0, 12);
            for (int unsigned i = 0; i < frame_len; i++) begin
                if ($urandom_range(0, 15) == 0)
                    pix_val = $urandom_range(0, 1) ? 255 : 0;
                else
                    pix_val = int'(center) + $urandom_range(0, 2 * spread) - int'(spread);
                if (pix_val < 0) pix_val = 0;
                if (pix_val > 255) pix_val = 255;
                send_pixel(PIXEL_BITS'(pix_val), i == frame_len - 1, 1'b0, '0);
            end
            if (frames_sent == pause_frame) drain_results();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("%0d pixels in %0d frames (longest random frame %0d), %0d results checked",
                 pixels_sent, frames_sent, longest_frame, results_seen);
        $display("thresholds seen from %0d to %0d", thr_lo, thr_hi);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

    // receiver holds ready or stalled for random stretches, some long enough to hold results back
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            m_tready <= $urandom_range(0, 2) != 0;
            ready_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 400)
                                                     : $urandom_range(1, 8);
        end else begin
            ready_left--;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[THR_BITS+COUNT_BITS-1:0];
            got = '{m_tdata[THR_BITS-1:0], m_tdata[THR_BITS+COUNT_BITS-1:THR_BITS]};
            results_seen++;
            if (got.thr < thr_lo) thr_lo = got.thr;
            if (got.thr > thr_hi) thr_hi = got.thr;
            if (pending_results.size() == 0) begin
                report_mismatch("result with none pending, threshold", got.thr, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.thr !== want.thr) report_mismatch("threshold", got.thr, want.thr);
                if (got.cnt !== want.cnt) report_mismatch("pixel count", got.cnt, want.cnt);
            end
        end
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+hdl
hdl/hmt_pkg.sv
hdl/hmt_ram.sv
hdl/hmt_ctrl.sv
hdl/hmt_dp.sv
hdl/histogram_median_threshold.sv
tb/histogram_median_threshold_test.sv
